FILE: hdl/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// shared types and constants for the markup tag stripper
// ---------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int TAG_LIMIT   = 64;
    localparam int STORE_DEPTH = TAG_LIMIT - 1;
    localparam int CNT_W       = $clog2(TAG_LIMIT);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] OPEN_CH  = 8'h3C;
    localparam logic [7:0] CLOSE_CH = 8'h3E;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_OUTSIDE,
        MODE_HOLDING,
        MODE_PASSING
    } scan_mode_t;

    // what follows the held bytes of a job
    typedef enum logic [1:0] {
        TAIL_BYTE,
        TAIL_NONE,
        TAIL_EMPTY
    } tail_kind_t;

    typedef struct packed {
        tail_kind_t       tail;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       tail_byte;
    } job_t;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_FLUSH,
        BACK_TAIL
    } back_state_t;

endpackage

`default_nettype wire

FILE: hdl/mts_front.sv
// ---------------------------------------------------------------------------
// mts_front
// accepts words, tracks tag state, writes held bytes and issues jobs
// ---------------------------------------------------------------------------
`default_nettype none

module mts_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire logic             command,
    input  wire logic [7:0]       data_byte,
    input  wire logic             queue_full,
    input  wire logic             flush_end,
    output logic                  push,
    output mts_pkg::job_t         push_job,
    output mts_pkg::store_wr_t    store_wr
);

    mts_pkg::scan_mode_t           mode_reg, mode_next;
    logic [mts_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          pending_reg, pending_next;
    logic                          accept;

    assign item_stall = queue_full || pending_reg;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mts_pkg::MODE_OUTSIDE;
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        count_next         = count_reg;
        pending_next       = pending_reg && !flush_end;
        push               = 1'b0;
        push_job.tail      = mts_pkg::TAIL_BYTE;
        push_job.cnt       = '0;
        push_job.tail_byte = data_byte;
        store_wr.en        = 1'b0;
        store_wr.addr      = count_reg;
        store_wr.data      = data_byte;

        if (accept)
        begin
            if (command == mts_pkg::CMD_END)
            begin
                push          = 1'b1;
                push_job.cnt  = count_reg;
                push_job.tail = (count_reg == '0) ? mts_pkg::TAIL_EMPTY
                                                  : mts_pkg::TAIL_NONE;
                pending_next  = (count_reg != '0);
                mode_next     = mts_pkg::MODE_OUTSIDE;
                count_next    = '0;
            end
            else
            begin
                unique case (mode_reg)
                    mts_pkg::MODE_HOLDING:
                    begin
                        if (count_reg < mts_pkg::CNT_W'(mts_pkg::STORE_DEPTH))
                        begin
                            if (data_byte == mts_pkg::CLOSE_CH)
                            begin
                                count_next = '0;
                                mode_next  = mts_pkg::MODE_OUTSIDE;
                            end
                            else
                            begin
                                store_wr.en = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            // tag hit the limit: flush it and pass until '>'
                            push         = 1'b1;
                            push_job.cnt = count_reg;
                            pending_next = 1'b1;
                            count_next   = '0;
                            mode_next    = (data_byte == mts_pkg::CLOSE_CH)
                                         ? mts_pkg::MODE_OUTSIDE
                                         : mts_pkg::MODE_PASSING;
                        end
                    end
                    mts_pkg::MODE_PASSING:
                    begin
                        push = 1'b1;
                        if (data_byte == mts_pkg::CLOSE_CH)
                        begin
                            mode_next = mts_pkg::MODE_OUTSIDE;
                        end
                    end
                    default:
                    begin
                        mode_next = mts_pkg::MODE_OUTSIDE;
                        if (data_byte == mts_pkg::OPEN_CH)
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.addr = '0;
                            count_next    = mts_pkg::CNT_W'(1);
                            mode_next     = mts_pkg::MODE_HOLDING;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    property p_no_accept_while_flushing;
        @(posedge clk) disable iff (!rst_n)
        pending_reg |-> !accept;
    endproperty
    a_no_accept_while_flushing: assert property (p_no_accept_while_flushing)
        else $error("word taken while a flush is outstanding");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= mts_pkg::CNT_W'(mts_pkg::STORE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("held count beyond store depth");

    property p_idle_outside;
        @(posedge clk) disable iff (!rst_n)
        (mode_reg == mts_pkg::MODE_OUTSIDE) |-> (count_reg == '0);
    endproperty
    a_idle_outside: assert property (p_idle_outside)
        else $error("bytes held outside a tag");

endmodule

`default_nettype wire

FILE: hdl/mts_queue.sv
// ---------------------------------------------------------------------------
// mts_queue
// short job queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module mts_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mts_pkg::job_t push_job,
    output logic               full,
    output logic               head_valid,
    output mts_pkg::job_t      head_job,
    input  wire logic          pop
);

    localparam int PTR_W = $clog2(mts_pkg::QUEUE_DEPTH);
    localparam int LVL_W = $clog2(mts_pkg::QUEUE_DEPTH + 1);

    mts_pkg::job_t       slot_reg [0:mts_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0]    level_reg;

    assign full       = (level_reg == LVL_W'(mts_pkg::QUEUE_DEPTH));
    assign head_valid = (level_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(mts_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(mts_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mts_back.sv
// ---------------------------------------------------------------------------
// mts_back
// holds the tag store and turns jobs into result words
// ---------------------------------------------------------------------------
`default_nettype none

module mts_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mts_pkg::store_wr_t  store_wr,
    input  wire logic                head_valid,
    input  wire mts_pkg::job_t       head_job,
    output logic                     pop,
    output logic                     flush_end,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [7:0]               out_byte,
    output logic                     byte_valid,
    output logic                     run_last,
    output logic                     text_done
);

    logic [7:0]                tag_mem [0:mts_pkg::STORE_DEPTH-1];
    logic [7:0]                rd_data_reg;
    logic                      rd_en;
    logic [mts_pkg::CNT_W-1:0] rd_addr;

    mts_pkg::back_state_t      state_reg, state_next;
    mts_pkg::job_t             job_reg, job_next;
    logic [mts_pkg::CNT_W-1:0] idx_reg, idx_next;

    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      bvalid_reg, bvalid_next;
    logic                      last_reg, last_next;
    logic                      done_reg, done_next;
    logic                      slot_free;
    logic                      at_last_held;

    assign result_valid = valid_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = bvalid_reg;
    assign run_last     = last_reg;
    assign text_done    = done_reg;

    assign slot_free    = !valid_reg || !result_stall;
    assign at_last_held = (idx_reg == job_reg.cnt - 1'b1);

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            tag_mem[store_wr.addr] <= store_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::BACK_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        idx_reg    <= idx_next;
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && result_stall;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        pop         = 1'b0;
        flush_end   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            mts_pkg::BACK_IDLE:
            begin
                if (head_valid && slot_free)
                begin
                    pop      = 1'b1;
                    job_next = head_job;
                    if (head_job.cnt != '0)
                    begin
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = mts_pkg::BACK_FLUSH;
                    end
                    else
                    begin
                        valid_next  = 1'b1;
                        bvalid_next = (head_job.tail == mts_pkg::TAIL_BYTE);
                        byte_next   = (head_job.tail == mts_pkg::TAIL_BYTE)
                                    ? head_job.tail_byte : 8'h00;
                        last_next   = 1'b1;
                        done_next   = (head_job.tail == mts_pkg::TAIL_EMPTY);
                    end
                end
            end
            mts_pkg::BACK_FLUSH:
            begin
                if (slot_free)
                begin
                    // the next read is issued on the same edge the word leaves
                    valid_next  = 1'b1;
                    bvalid_next = 1'b1;
                    byte_next   = rd_data_reg;
                    last_next   = at_last_held && (job_reg.tail == mts_pkg::TAIL_NONE);
                    done_next   = at_last_held && (job_reg.tail == mts_pkg::TAIL_NONE);
                    if (at_last_held)
                    begin
                        flush_end  = 1'b1;
                        state_next = (job_reg.tail == mts_pkg::TAIL_BYTE)
                                   ? mts_pkg::BACK_TAIL : mts_pkg::BACK_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            mts_pkg::BACK_TAIL:
            begin
                if (slot_free)
                begin
                    valid_next  = 1'b1;
                    bvalid_next = 1'b1;
                    byte_next   = job_reg.tail_byte;
                    last_next   = 1'b1;
                    done_next   = 1'b0;
                    state_next  = mts_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::BACK_IDLE;
            end
        endcase
    end

    property p_done_is_last;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && text_done) |-> run_last;
    endproperty
    a_done_is_last: assert property (p_done_is_last)
        else $error("end marker on a word that is not last");

    property p_empty_word;
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !byte_valid) |-> (text_done && out_byte == 8'h00);
    endproperty
    a_empty_word: assert property (p_empty_word)
        else $error("empty word outside end of text");

    property p_flush_index;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == mts_pkg::BACK_FLUSH) |-> (idx_reg < job_reg.cnt);
    endproperty
    a_flush_index: assert property (p_flush_index)
        else $error("flush index past held count");

endmodule

`default_nettype wire

FILE: hdl/markup_tag_stripper_unit.sv
// path: a passed byte goes through the job queue, then the output register
// throughput: one byte per cycle outside tags while item_stall is low; held bytes go to the tag store
// a flush of n held bytes streams from the tag store read port at one per cycle unless stalled;
// the front takes no word from flush issue until the last held byte is read out
// reset: rst_n (async, active low) clears scan state, held count, queue and output valid;
// the tag store is not cleared and needs no clearing pass
`default_nettype none

module markup_tag_stripper_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       command,
    input  wire logic [7:0] data_byte,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            text_done
);

    logic                 push;
    mts_pkg::job_t        push_job;
    mts_pkg::store_wr_t   store_wr;
    logic                 queue_full;
    logic                 head_valid;
    mts_pkg::job_t        head_job;
    logic                 pop;
    logic                 flush_end;

    mts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .flush_end  (flush_end),
        .push       (push),
        .push_job   (push_job),
        .store_wr   (store_wr)
    );

    mts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    mts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .store_wr     (store_wr),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .flush_end    (flush_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .run_last     (run_last),
        .text_done    (text_done)
    );

endmodule

`default_nettype wire
